>>> rtl/core/lfu_pkg.sv
`default_nettype none

package lfu_pkg;

   localparam int CAPACITY   = 16;
   localparam int KEY_BITS   = 32;
   localparam int COUNT_BITS = 16;
   localparam int DATA_BITS  = 32;
   localparam int CFG_BITS   = 5;

   localparam int IDX_BITS  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int RANK_BITS = IDX_BITS;
   localparam int OCC_BITS  = $clog2(CAPACITY + 1);
   localparam int CMP_BITS  = (OCC_BITS > CFG_BITS) ? OCC_BITS : CFG_BITS;

   localparam logic [CFG_BITS-1:0]   CAP_RESET = CFG_BITS'(16);
   localparam logic [IDX_BITS-1:0]   LAST_IDX  = IDX_BITS'(CAPACITY - 1);
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

   localparam logic FUNC_GET = 1'b0;
   localparam logic FUNC_PUT = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_UPDATE
   } state_type;

   typedef struct packed {
      logic                  valid;
      logic [KEY_BITS-1:0]   key;
      logic [DATA_BITS-1:0]  value;
      logic [COUNT_BITS-1:0] count;
      logic [RANK_BITS-1:0]  rank;
   } entry_type;

   // touch: hit update at slot; insert: new entry at slot, evict when slot held the victim
   typedef struct packed {
      logic                 en;
      logic                 touch;
      logic                 put;
      logic                 insert;
      logic                 evict;
      logic [IDX_BITS-1:0]  slot;
      logic [RANK_BITS-1:0] pivot_rank;
      logic [KEY_BITS-1:0]  key;
      logic [DATA_BITS-1:0] value;
   } commit_type;

   typedef struct packed {
      logic                 hit;
      logic [DATA_BITS-1:0] read_value;
      logic                 evicted;
      logic [DATA_BITS-1:0] evicted_key;
   } result_type;

endpackage

`default_nettype wire

>>> rtl/core/lfu_if.sv
`default_nettype none

interface lfu_req_if;
   logic                          valid;
   logic                          ready;
   logic                          func;
   logic [lfu_pkg::DATA_BITS-1:0] key;
   logic [lfu_pkg::DATA_BITS-1:0] value;

   modport source (output valid, output func, output key, output value, input ready);
   modport sink (input valid, input func, input key, input value, output ready);
endinterface

interface lfu_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          hit;
   logic [lfu_pkg::DATA_BITS-1:0] read_value;
   logic                          evicted;
   logic [lfu_pkg::DATA_BITS-1:0] evicted_key;

   modport source (output valid, output hit, output read_value, output evicted,
                   output evicted_key, input ready);
   modport sink (input valid, input hit, input read_value, input evicted,
                 input evicted_key, output ready);
endinterface

`default_nettype wire

>>> rtl/core/lfu_store.sv
`default_nettype none

module lfu_store (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic [lfu_pkg::IDX_BITS-1:0]   rd_idx,
   output lfu_pkg::entry_type                  rd_entry,
   output logic      [lfu_pkg::OCC_BITS-1:0]   occupancy,
   input  wire lfu_pkg::commit_type            commit
);

   logic [lfu_pkg::CAPACITY-1:0]   valid_ff;
   logic [lfu_pkg::KEY_BITS-1:0]   key_ff   [lfu_pkg::CAPACITY];
   logic [lfu_pkg::DATA_BITS-1:0]  value_ff [lfu_pkg::CAPACITY];
   logic [lfu_pkg::COUNT_BITS-1:0] count_ff [lfu_pkg::CAPACITY];
   logic [lfu_pkg::RANK_BITS-1:0]  rank_ff  [lfu_pkg::CAPACITY];
   logic [lfu_pkg::OCC_BITS-1:0]   occ_ff;

   assign rd_entry.valid = valid_ff[rd_idx];
   assign rd_entry.key   = key_ff[rd_idx];
   assign rd_entry.value = value_ff[rd_idx];
   assign rd_entry.count = count_ff[rd_idx];
   assign rd_entry.rank  = rank_ff[rd_idx];
   assign occupancy      = occ_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         occ_ff   <= '0;
      end else if (commit.en && commit.insert) begin
         valid_ff[commit.slot] <= 1'b1;
         if (!commit.evict) begin
            occ_ff <= occ_ff + 1'b1;
         end
      end
   end

   // per-entry lanes; an evict-then-insert nets to -1+1 above the victim's rank
   always_ff @(posedge clock) begin
      for (int i = 0; i < lfu_pkg::CAPACITY; i++) begin
         if (commit.en && commit.touch) begin
            if (lfu_pkg::IDX_BITS'(i) == commit.slot) begin
               rank_ff[i] <= '0;
               if (count_ff[i] != lfu_pkg::COUNT_MAX) begin
                  count_ff[i] <= count_ff[i] + 1'b1;
               end
               if (commit.put) begin
                  value_ff[i] <= commit.value;
               end
            end else if (valid_ff[i] && rank_ff[i] < commit.pivot_rank) begin
               rank_ff[i] <= rank_ff[i] + 1'b1;
            end
         end else if (commit.en && commit.insert) begin
            if (lfu_pkg::IDX_BITS'(i) == commit.slot) begin
               key_ff[i]   <= commit.key;
               value_ff[i] <= commit.value;
               count_ff[i] <= lfu_pkg::COUNT_BITS'(1);
               rank_ff[i]  <= '0;
            end else if (valid_ff[i]) begin
               if (!(commit.evict && rank_ff[i] > commit.pivot_rank)) begin
                  rank_ff[i] <= rank_ff[i] + 1'b1;
               end
            end
         end
      end
   end

endmodule

`default_nettype wire

>>> rtl/core/lfu_ctrl.sv
`default_nettype none

module lfu_ctrl (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire logic                           req_func,
   input  wire logic [lfu_pkg::DATA_BITS-1:0]  req_key,
   input  wire logic [lfu_pkg::DATA_BITS-1:0]  req_value,
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output lfu_pkg::result_type                 rsp_result,
   input  wire logic [lfu_pkg::CFG_BITS-1:0]   capacity,
   output logic      [lfu_pkg::IDX_BITS-1:0]   rd_idx,
   input  wire lfu_pkg::entry_type             rd_entry,
   input  wire logic [lfu_pkg::OCC_BITS-1:0]   occupancy,
   output lfu_pkg::commit_type                 commit
);

   lfu_pkg::state_type state_ff, state_in;
   logic [lfu_pkg::IDX_BITS-1:0] idx_ff, idx_in;

   logic                           func_ff;
   logic [lfu_pkg::KEY_BITS-1:0]   key_ff;
   logic [lfu_pkg::DATA_BITS-1:0]  value_ff;

   logic                           found_ff;
   logic [lfu_pkg::IDX_BITS-1:0]   found_idx_ff;
   logic [lfu_pkg::RANK_BITS-1:0]  found_rank_ff;
   logic [lfu_pkg::DATA_BITS-1:0]  found_value_ff;
   logic                           free_ff;
   logic [lfu_pkg::IDX_BITS-1:0]   free_idx_ff;
   logic                           vic_ff;
   logic [lfu_pkg::IDX_BITS-1:0]   vic_idx_ff;
   logic [lfu_pkg::COUNT_BITS-1:0] vic_count_ff;
   logic [lfu_pkg::RANK_BITS-1:0]  vic_rank_ff;
   logic [lfu_pkg::KEY_BITS-1:0]   vic_key_ff;

   logic                           out_valid_ff;
   lfu_pkg::result_type            out_ff;

   logic                           req_fire;
   logic                           out_free;
   logic                           scan_en;
   logic                           commit_en;
   logic                           is_match;
   logic                           beats_vic;
   logic [lfu_pkg::CMP_BITS-1:0]   cap_sat;
   logic                           full;
   lfu_pkg::commit_type            cm;
   lfu_pkg::result_type            res;

   assign out_free  = !out_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;
   assign rd_idx    = idx_ff;
   assign rsp_valid = out_valid_ff;
   assign rsp_result = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lfu_pkg::ST_IDLE;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      idx_in    = idx_ff;
      req_ready = 1'b0;
      scan_en   = 1'b0;
      commit_en = 1'b0;
      unique case (state_ff)
         lfu_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               state_in = lfu_pkg::ST_SCAN;
               idx_in   = '0;
            end
         end
         lfu_pkg::ST_SCAN: begin
            scan_en = 1'b1;
            idx_in  = idx_ff + 1'b1;
            if (idx_ff == lfu_pkg::LAST_IDX) begin
               state_in = lfu_pkg::ST_UPDATE;
            end
         end
         lfu_pkg::ST_UPDATE: begin
            if (out_free) begin
               commit_en = 1'b1;
               state_in  = lfu_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = lfu_pkg::ST_IDLE;
         end
      endcase
   end

   // shared compare unit: key match, first free slot and victim order, one entry a cycle
   assign is_match  = rd_entry.valid && rd_entry.key == key_ff;
   assign beats_vic = rd_entry.valid &&
                      (!vic_ff || rd_entry.count < vic_count_ff ||
                       (rd_entry.count == vic_count_ff && rd_entry.rank > vic_rank_ff));

   always_ff @(posedge clock) begin
      if (req_fire) begin
         func_ff  <= req_func;
         key_ff   <= lfu_pkg::KEY_BITS'(req_key);
         value_ff <= req_value;
      end
      if (scan_en && is_match && !found_ff) begin
         found_idx_ff   <= idx_ff;
         found_rank_ff  <= rd_entry.rank;
         found_value_ff <= rd_entry.value;
      end
      if (scan_en && !rd_entry.valid && !free_ff) begin
         free_idx_ff <= idx_ff;
      end
      if (scan_en && beats_vic) begin
         vic_idx_ff   <= idx_ff;
         vic_count_ff <= rd_entry.count;
         vic_rank_ff  <= rd_entry.rank;
         vic_key_ff   <= rd_entry.key;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || req_fire) begin
         found_ff <= 1'b0;
         free_ff  <= 1'b0;
         vic_ff   <= 1'b0;
      end else if (scan_en) begin
         if (is_match) begin
            found_ff <= 1'b1;
         end
         if (!rd_entry.valid) begin
            free_ff <= 1'b1;
         end
         if (beats_vic) begin
            vic_ff <= 1'b1;
         end
      end
   end

   assign cap_sat = (lfu_pkg::CMP_BITS'(capacity) > lfu_pkg::CMP_BITS'(lfu_pkg::CAPACITY))
                    ? lfu_pkg::CMP_BITS'(lfu_pkg::CAPACITY) : lfu_pkg::CMP_BITS'(capacity);
   assign full    = lfu_pkg::CMP_BITS'(occupancy) >= cap_sat;

   always_comb begin
      cm       = '0;
      res      = '0;
      cm.key   = key_ff;
      cm.value = value_ff;
      if (found_ff) begin
         res.hit        = 1'b1;
         res.read_value = (func_ff == lfu_pkg::FUNC_PUT) ? '0 : found_value_ff;
         cm.touch       = 1'b1;
         cm.put         = func_ff == lfu_pkg::FUNC_PUT;
         cm.slot        = found_idx_ff;
         cm.pivot_rank  = found_rank_ff;
      end else if (func_ff == lfu_pkg::FUNC_PUT && cap_sat != '0) begin
         if (full && vic_ff) begin
            cm.insert       = 1'b1;
            cm.evict        = 1'b1;
            cm.slot         = vic_idx_ff;
            cm.pivot_rank   = vic_rank_ff;
            res.evicted     = 1'b1;
            res.evicted_key = lfu_pkg::DATA_BITS'(vic_key_ff);
         end else if (free_ff) begin
            cm.insert = 1'b1;
            cm.slot   = free_idx_ff;
         end
      end
      cm.en  = commit_en;
      commit = cm;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (commit_en) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (commit_en) begin
         out_ff <= res;
      end
   end

   a_commit_slot_free: assert property (@(posedge clock) disable iff (reset)
      commit.en |-> out_free)
      else $error("commit while result beat still pending");

   a_commit_exclusive: assert property (@(posedge clock) disable iff (reset)
      commit.en |-> !(commit.touch && commit.insert))
      else $error("hit update and insert in one commit");

   a_accept_starts_scan: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff == lfu_pkg::ST_SCAN && idx_ff == '0))
      else $error("accepted beat did not start a scan");

   a_rsp_after_update: assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> $past(commit_en))
      else $error("result appeared without a commit");

endmodule

`default_nettype wire

>>> rtl/core/lfu_cache_with_lru_tiebreak.sv
// channel  dir  handshake          payload
// req_bus  in   valid/ready        func, key, value
// rsp_bus  out  valid/ready        hit, read_value, evicted, evicted_key
// csr      in   csr_wr_en (write)  csr_wr_data = capacity_in_use
//
// Each beat passes through accept, a scan of all entries in the entry store through
// the shared key/victim compare unit (one entry a cycle), and an update step.
// Reset clears all valid bits and occupancy at once; capacity resets to 16.
// The update cycle waits while a previous result beat is still unread; a new
// request is taken while the finished result waits in the output register.
`default_nettype none

module lfu_cache_with_lru_tiebreak (
   input  wire logic                          clock,
   input  wire logic                          reset,
   lfu_req_if.sink                            req_bus,
   lfu_rsp_if.source                          rsp_bus,
   input  wire logic                          csr_wr_en,
   input  wire logic [lfu_pkg::CFG_BITS-1:0]  csr_wr_data
);

   logic [lfu_pkg::CFG_BITS-1:0] cap_ff;
   logic [lfu_pkg::IDX_BITS-1:0] rd_idx;
   logic [lfu_pkg::OCC_BITS-1:0] occupancy;
   lfu_pkg::entry_type           rd_entry;
   lfu_pkg::commit_type          commit;
   lfu_pkg::result_type          rsp_result;

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= lfu_pkg::CAP_RESET;
      end else if (csr_wr_en) begin
         cap_ff <= csr_wr_data;
      end
   end

   lfu_store u_store (
      .clock     (clock),
      .reset     (reset),
      .rd_idx    (rd_idx),
      .rd_entry  (rd_entry),
      .occupancy (occupancy),
      .commit    (commit)
   );

   lfu_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_bus.valid),
      .req_ready  (req_bus.ready),
      .req_func   (req_bus.func),
      .req_key    (req_bus.key),
      .req_value  (req_bus.value),
      .rsp_valid  (rsp_bus.valid),
      .rsp_ready  (rsp_bus.ready),
      .rsp_result (rsp_result),
      .capacity   (cap_ff),
      .rd_idx     (rd_idx),
      .rd_entry   (rd_entry),
      .occupancy  (occupancy),
      .commit     (commit)
   );

   assign rsp_bus.hit         = rsp_result.hit;
   assign rsp_bus.read_value  = rsp_result.read_value;
   assign rsp_bus.evicted     = rsp_result.evicted;
   assign rsp_bus.evicted_key = rsp_result.evicted_key;

endmodule

`default_nettype wire

>>> tb/tb_lfu_cache_with_lru_tiebreak.sv
`default_nettype none

class lfu_mirror;
   logic                            live [lfu_pkg::CAPACITY];
   logic [lfu_pkg::KEY_BITS-1:0]    keys [lfu_pkg::CAPACITY];
   logic [lfu_pkg::DATA_BITS-1:0]   vals [lfu_pkg::CAPACITY];
   logic [lfu_pkg::COUNT_BITS-1:0]  uses [lfu_pkg::CAPACITY];
   logic [lfu_pkg::RANK_BITS-1:0]   age  [lfu_pkg::CAPACITY];
   int unsigned                     occupancy;
   logic [lfu_pkg::CFG_BITS-1:0]    capacity;
   lfu_pkg::result_type             awaited_results [$];
   int                              errors;
   int                              checked;
   int                              hits;
   int                              evictions;

   function new();
      foreach (live[i]) begin
         live[i] = 1'b0;
         keys[i] = '0;
         vals[i] = '0;
         uses[i] = '0;
         age[i]  = '0;
      end
      occupancy = 0;
      capacity  = lfu_pkg::CAP_RESET;
      errors    = 0;
      checked   = 0;
      hits      = 0;
      evictions = 0;
   endfunction

   // most recent gets rank 0, younger entries age by one
   function void promote(int idx);
      foreach (live[i])
         if (live[i] && i != idx && age[i] < age[idx])
            age[i] = age[i] + 1'b1;
      age[idx] = '0;
      if (uses[idx] != lfu_pkg::COUNT_MAX)
         uses[idx] = uses[idx] + 1'b1;
   endfunction

   function void apply_request(logic func, logic [lfu_pkg::KEY_BITS-1:0] key,
                               logic [lfu_pkg::DATA_BITS-1:0] value);
      lfu_pkg::result_type          res;
      int                           found;
      int                           slot;
      int                           vic;
      int                           lim;
      logic [lfu_pkg::RANK_BITS-1:0] pivot;
      res   = '0;
      found = -1;
      slot  = -1;
      vic   = -1;
      lim   = (capacity > lfu_pkg::CAPACITY) ? lfu_pkg::CAPACITY : int'(capacity);
      foreach (live[i])
         if (found < 0 && live[i] && keys[i] == key)
            found = i;
      if (found >= 0) begin
         res.hit = 1'b1;
         promote(found);
         if (func == lfu_pkg::FUNC_GET)
            res.read_value = vals[found];
         else
            vals[found] = value;
      end else if (func == lfu_pkg::FUNC_PUT && lim != 0) begin
         if (occupancy >= lim) begin
            foreach (live[i]) begin
               if (!live[i])
                  continue;
               if (vic < 0 || uses[i] < uses[vic] ||
                   (uses[i] == uses[vic] && age[i] > age[vic]))
                  vic = i;
            end
            if (vic >= 0) begin
               pivot           = age[vic];
               res.evicted     = 1'b1;
               res.evicted_key = keys[vic];
               live[vic]       = 1'b0;
               if (occupancy > 0)
                  occupancy--;
               foreach (live[i])
                  if (live[i] && age[i] > pivot)
                     age[i] = age[i] - 1'b1;
               slot = vic;
            end
         end
         if (slot < 0)
            foreach (live[i])
               if (slot < 0 && !live[i])
                  slot = i;
         if (slot >= 0) begin
            foreach (live[i])
               if (live[i])
                  age[i] = age[i] + 1'b1;
            live[slot] = 1'b1;
            keys[slot] = key;
            vals[slot] = value;
            uses[slot] = lfu_pkg::COUNT_BITS'(1);
            age[slot]  = '0;
            occupancy++;
         end
      end
      awaited_results.push_back(res);
   endfunction

   function void check_result(lfu_pkg::result_type got);
      lfu_pkg::result_type want;
      if (awaited_results.size() == 0) begin
         $error("result beat with nothing outstanding");
         errors++;
         return;
      end
      want = awaited_results.pop_front();
      checked++;
      if (want.hit)
         hits++;
      if (want.evicted)
         evictions++;
      if (got.hit !== want.hit) begin
         $error("hit: expected %0d, got %0d", want.hit, got.hit);
         errors++;
      end
      if (got.read_value !== want.read_value) begin
         $error("read_value: expected %h, got %h", want.read_value, got.read_value);
         errors++;
      end
      if (got.evicted !== want.evicted) begin
         $error("evicted: expected %0d, got %0d", want.evicted, got.evicted);
         errors++;
      end
      if (got.evicted_key !== want.evicted_key) begin
         $error("evicted_key: expected %h, got %h", want.evicted_key, got.evicted_key);
         errors++;
      end
   endfunction
endclass

module tb_lfu_cache_with_lru_tiebreak;

   localparam int IDLE_LIMIT = 2000;
   localparam int HOLD_OFF   = 300;
   localparam int PHASE_LEN  = 63;

   logic                          clock;
   logic                          reset;
   logic                          csr_wr_en;
   logic [lfu_pkg::CFG_BITS-1:0]  csr_wr_data;

   lfu_req_if req_bus ();
   lfu_rsp_if rsp_bus ();

   lfu_cache_with_lru_tiebreak uut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   lfu_mirror   mirror = new();
   logic [31:0] key_pool [0:47];
   logic        src_steady;
   logic        snk_steady;
   logic        hold_off_request;
   int          idle_cycles;
   int          settings;

   initial clock = 1'b0;
   always #10 clock = ~clock;

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(99);
      if (roll < 55)
         return 0;
      if (roll < 85)
         return $urandom_range(3, 1);
      if (roll < 97)
         return $urandom_range(12, 4);
      return $urandom_range(60, 20);
   endfunction

   task automatic send_beat(input logic func, input logic [31:0] key, input logic [31:0] value);
      int gap;
      req_bus.valid <= 1'b1;
      req_bus.func  <= func;
      req_bus.key   <= key;
      req_bus.value <= value;
      @(posedge clock);
      while (!req_bus.ready)
         @(posedge clock);
      gap = src_steady ? 0 : pick_gap();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic random_beat(input int span);
      logic        func;
      logic [31:0] key;
      int          roll;
      roll = $urandom_range(99);
      func = ($urandom_range(99) < 55) ? lfu_pkg::FUNC_PUT : lfu_pkg::FUNC_GET;
      if (roll < 85)
         key = key_pool[$urandom_range(span - 1)];
      else if (roll < 95)
         key = $urandom;
      else
         key = $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
      send_beat(func, key, $urandom);
   endtask

   task automatic drain();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (mirror.awaited_results.size() != 0)
         @(posedge clock);
   endtask

   task automatic set_capacity(input logic [lfu_pkg::CFG_BITS-1:0] cap);
      drain();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= cap;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      mirror.capacity = cap;
      settings++;
   endtask

   // result sink: random stalls, plus one long hold-off on request
   initial begin
      int stall;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_OFF) @(posedge clock);
         end else if (snk_steady) begin
            rsp_bus.ready <= 1'b1;
         end else begin
            stall = pick_gap();
            if (stall == 0) begin
               rsp_bus.ready <= 1'b1;
            end else begin
               rsp_bus.ready <= 1'b0;
               repeat (stall - 1) @(posedge clock);
            end
         end
      end
   end

   always @(posedge clock) begin
      lfu_pkg::result_type seen;
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            seen.hit         = rsp_bus.hit;
            seen.read_value  = rsp_bus.read_value;
            seen.evicted     = rsp_bus.evicted;
            seen.evicted_key = rsp_bus.evicted_key;
            mirror.check_result(seen);
         end
         if (req_bus.valid && req_bus.ready)
            mirror.apply_request(req_bus.func, req_bus.key, req_bus.value);
         if ((rsp_bus.valid && rsp_bus.ready) || (req_bus.valid && req_bus.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   initial begin
      logic [lfu_pkg::CFG_BITS-1:0] caps [0:9];
      int                           eff;
      int                           span;
      caps = '{5'd31, 5'd1, 5'd5, 5'd0, 5'd16, 5'd2, 5'd8, 5'd12, 5'd3, 5'd20};
      key_pool[0] = 32'h0;
      key_pool[1] = 32'hFFFF_FFFF;
      for (int i = 2; i < 48; i++)
         key_pool[i] = $urandom;
      src_steady       = 1'b0;
      snk_steady       = 1'b0;
      hold_off_request = 1'b0;
      idle_cycles      = 0;
      settings         = 0;
      reset         <= 1'b1;
      csr_wr_en     <= 1'b0;
      csr_wr_data   <= '0;
      req_bus.valid <= 1'b0;
      req_bus.func  <= lfu_pkg::FUNC_GET;
      req_bus.key   <= '0;
      req_bus.value <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed: empty miss, key/value extremes, put hit, fill, LFU/LRU victim
      send_beat(lfu_pkg::FUNC_GET, 32'h0, 32'hFFFF_FFFF);
      send_beat(lfu_pkg::FUNC_PUT, 32'h0, 32'hFFFF_FFFF);
      send_beat(lfu_pkg::FUNC_PUT, 32'hFFFF_FFFF, 32'h0);
      send_beat(lfu_pkg::FUNC_GET, 32'h0, 32'h0);
      send_beat(lfu_pkg::FUNC_GET, 32'hFFFF_FFFF, 32'h0);
      send_beat(lfu_pkg::FUNC_PUT, 32'h0, 32'h1234_5678);
      for (int i = 1; i <= 14; i++)
         send_beat(lfu_pkg::FUNC_PUT, 32'(i), $urandom);
      send_beat(lfu_pkg::FUNC_PUT, 32'hA5A5_5A5A, 32'h5A5A_A5A5);
      send_beat(lfu_pkg::FUNC_GET, 32'h1, 32'h0);
      // shrink below occupancy, then no room at all
      set_capacity(5'd4);
      send_beat(lfu_pkg::FUNC_PUT, 32'h8000_0001, 32'h7FFF_FFFE);
      set_capacity(5'd0);
      send_beat(lfu_pkg::FUNC_PUT, 32'hC0DE_0000, 32'h1);
      send_beat(lfu_pkg::FUNC_GET, 32'h0, 32'h0);
      send_beat(lfu_pkg::FUNC_PUT, 32'hFFFF_FFFF, 32'hDEAD_0001);

      foreach (caps[p]) begin
         set_capacity(caps[p]);
         eff  = (caps[p] > lfu_pkg::CAPACITY) ? lfu_pkg::CAPACITY : int'(caps[p]);
         span = (eff == 0) ? 24 : eff + 6;
         src_steady = (p % 4 == 1);
         snk_steady = (p % 4 == 2);
         if (p == 2) begin
            hold_off_request = 1'b1;
            src_steady       = 1'b1;
            repeat (12) random_beat(span);
            src_steady       = 1'b0;
         end
         repeat (PHASE_LEN) random_beat(span);
      end

      drain();
      repeat (40) @(posedge clock);
      if (mirror.awaited_results.size() != 0) begin
         $error("%0d results never arrived", mirror.awaited_results.size());
         mirror.errors++;
      end
      $display("Checked %0d results over %0d capacity writes, capacity 0 to 31.",
               mirror.checked, settings);
      $display("Hits seen: %0d, evictions seen: %0d, errors: %0d.",
               mirror.hits, mirror.evictions, mirror.errors);
      if (mirror.errors == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

`default_nettype wire
